@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, masked while reset is held
`define FRWL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// concurrent assertion that also runs through reset
`define FRWL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/frwl_pkg.sv @@
// types and constants of the fair reader-writer lock unit
`timescale 1ns / 1ps

package frwl_pkg;

    // default number of queue entries
    localparam int QUEUE_DEPTH_DEF = 16;
    // requesters with a number at or above this are ignored
    localparam int REQUESTER_COUNT = 64;
    // width used to compare a requester number against the count
    localparam int ID_CMP_W = 9;
    // most results one item may cause in a grant drain
    localparam int MAX_RESULTS = 16;
    localparam int GRANT_CNT_W = $clog2(MAX_RESULTS + 1);
    // active reader counter
    localparam int RC_W = 7;
    localparam logic [RC_W-1:0] READER_MAX = 7'd127;

    localparam int OP_W = 2;
    localparam int ID_W = 6;
    localparam int ST_W = 3;
    localparam int ENTRY_W = ID_W + 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_ACQ_RD = 2'd0;
    localparam logic [OP_W-1:0] OP_REL_RD = 2'd1;
    localparam logic [OP_W-1:0] OP_ACQ_WR = 2'd2;
    localparam logic [OP_W-1:0] OP_REL_WR = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_GRANTED = 3'd0;
    localparam logic [ST_W-1:0] ST_QUEUED = 3'd1;
    localparam logic [ST_W-1:0] ST_WAITER = 3'd2;
    localparam logic [ST_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL = 3'd4;
    localparam logic [ST_W-1:0] ST_ERROR = 3'd5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic            load;
        logic            inc_rc;
        logic            dec_rc;
        logic            set_wh;
        logic            clr_wh;
        logic            push;
        logic            pop;
        logic            emit;
        logic [ST_W-1:0] status;
        logic            use_head;
        logic            wr;
        logic            last;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            id_ok;
        logic            rc_zero;
        logic            rc_one;
        logic            rc_max;
        logic            wh;
        logic            q_empty;
        logic            q_full;
        logic            head_wr;
        logic            grant_more;
        logic            out_free;
    } t_dp_sts;

endpackage

@@ rtl/frwl_datapath.sv @@
// lock state, wait queue and result register of the lock unit
`timescale 1ns / 1ps

module frwl_datapath #(
    parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [frwl_pkg::OP_W-1:0]   i_operation,
    input  logic [frwl_pkg::ID_W-1:0]   i_requester_id,
    input  frwl_pkg::t_dp_cmd           i_cmd,
    output frwl_pkg::t_dp_sts           o_sts,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [frwl_pkg::ST_W-1:0]   o_status,
    output logic [frwl_pkg::ID_W-1:0]   o_grant_id,
    output logic                        o_grant_is_writer,
    output logic                        o_last
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // latched item
    logic [frwl_pkg::OP_W-1:0] r_op;
    logic [frwl_pkg::ID_W-1:0] r_id;

    // lock state
    logic [frwl_pkg::RC_W-1:0] r_rc, n_rc;
    logic r_wh, n_wh;

    // wait queue
    logic [frwl_pkg::ENTRY_W-1:0] r_mem [QUEUE_DEPTH];
    logic [frwl_pkg::ENTRY_W-1:0] r_head_data, r_next_data;
    logic [PTR_W-1:0] r_head, n_head, r_tail, n_tail, head_nx, tail_nx;
    logic [CNT_W-1:0] r_count, n_count;
    logic [frwl_pkg::GRANT_CNT_W-1:0] r_ngrant, n_ngrant;

    // result register
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign head_nx = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
    assign tail_nx = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    // status toward the controller
    always_comb begin
        o_sts.op = r_op;
        o_sts.id_ok = (frwl_pkg::ID_CMP_W'(r_id) <
                       frwl_pkg::ID_CMP_W'(frwl_pkg::REQUESTER_COUNT));
        o_sts.rc_zero = (r_rc == '0);
        o_sts.rc_one = (r_rc == frwl_pkg::RC_W'(1));
        o_sts.rc_max = (r_rc >= frwl_pkg::READER_MAX);
        o_sts.wh = r_wh;
        o_sts.q_empty = (r_count == '0);
        o_sts.q_full = (r_count >= CNT_FULL);
        o_sts.head_wr = r_head_data[frwl_pkg::ID_W];
        // another reader follows this one in the same drain
        o_sts.grant_more = (r_count > CNT_W'(1))
            && (r_ngrant < frwl_pkg::GRANT_CNT_W'(frwl_pkg::MAX_RESULTS - 1))
            && (r_rc < frwl_pkg::READER_MAX - frwl_pkg::RC_W'(1))
            && !r_next_data[frwl_pkg::ID_W];
        o_sts.out_free = out_free;
    end

    // next values of the lock and queue state
    always_comb begin
        n_rc = r_rc;
        n_wh = r_wh;
        n_head = r_head;
        n_tail = r_tail;
        n_count = r_count;
        n_ngrant = r_ngrant;
        n_out_valid = r_out_valid;
        if (i_cmd.inc_rc) begin
            n_rc = r_rc + frwl_pkg::RC_W'(1);
        end else if (i_cmd.dec_rc) begin
            n_rc = r_rc - frwl_pkg::RC_W'(1);
        end
        if (i_cmd.set_wh) begin
            n_wh = 1'b1;
        end else if (i_cmd.clr_wh) begin
            n_wh = 1'b0;
        end
        if (i_cmd.push) begin
            n_tail = tail_nx;
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_head = head_nx;
            n_count = r_count - CNT_W'(1);
        end
        if (i_cmd.load) begin
            n_ngrant = '0;
        end else if (i_cmd.pop) begin
            n_ngrant = r_ngrant + frwl_pkg::GRANT_CNT_W'(1);
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc <= '0;
            r_wh <= 1'b0;
            r_head <= '0;
            r_tail <= '0;
            r_count <= '0;
            r_ngrant <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rc <= n_rc;
            r_wh <= n_wh;
            r_head <= n_head;
            r_tail <= n_tail;
            r_count <= n_count;
            r_ngrant <= n_ngrant;
            r_out_valid <= n_out_valid;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_id <= i_requester_id;
        end
    end

    // queue memory: one write port, head and head plus one read registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= {(r_op == frwl_pkg::OP_ACQ_WR), r_id};
        end
        r_head_data <= r_mem[r_head];
        r_next_data <= r_mem[head_nx];
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status <= i_cmd.status;
            o_grant_id <= i_cmd.use_head ? r_head_data[frwl_pkg::ID_W-1:0] : r_id;
            o_grant_is_writer <= i_cmd.wr;
            o_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/frwl_ctrl.sv @@
// sequencing state machine of the lock unit
`timescale 1ns / 1ps

module frwl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  frwl_pkg::t_dp_sts i_sts,
    output frwl_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_GRANT = 2'd2;
    localparam logic [1:0] S_GWAIT = 2'd3;

    logic [1:0] r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    // decisions per state
    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    if (i_sts.id_ok) begin
                        o_cmd.last = 1'b1;
                        unique case (i_sts.op)
                            frwl_pkg::OP_ACQ_RD: begin
                                o_cmd.emit = 1'b1;
                                if (!i_sts.wh && i_sts.q_empty) begin
                                    if (i_sts.rc_max) begin
                                        o_cmd.status = frwl_pkg::ST_FULL;
                                    end else begin
                                        o_cmd.inc_rc = 1'b1;
                                        o_cmd.status = frwl_pkg::ST_GRANTED;
                                    end
                                end else if (i_sts.q_full) begin
                                    o_cmd.status = frwl_pkg::ST_FULL;
                                end else begin
                                    o_cmd.push = 1'b1;
                                    o_cmd.status = frwl_pkg::ST_QUEUED;
                                end
                            end
                            frwl_pkg::OP_REL_RD: begin
                                if (i_sts.rc_zero) begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.status = frwl_pkg::ST_ERROR;
                                end else begin
                                    o_cmd.dec_rc = 1'b1;
                                    if (i_sts.rc_one && !i_sts.wh && !i_sts.q_empty) begin
                                        n_state = S_GRANT;
                                    end else begin
                                        o_cmd.emit = 1'b1;
                                        o_cmd.status = frwl_pkg::ST_RELEASED;
                                    end
                                end
                            end
                            frwl_pkg::OP_ACQ_WR: begin
                                o_cmd.emit = 1'b1;
                                o_cmd.wr = 1'b1;
                                if (!i_sts.wh && i_sts.rc_zero) begin
                                    o_cmd.set_wh = 1'b1;
                                    o_cmd.status = frwl_pkg::ST_GRANTED;
                                end else if (i_sts.q_full) begin
                                    o_cmd.status = frwl_pkg::ST_FULL;
                                end else begin
                                    o_cmd.push = 1'b1;
                                    o_cmd.status = frwl_pkg::ST_QUEUED;
                                end
                            end
                            frwl_pkg::OP_REL_WR: begin
                                o_cmd.wr = 1'b1;
                                if (!i_sts.wh) begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.status = frwl_pkg::ST_ERROR;
                                end else begin
                                    o_cmd.clr_wh = 1'b1;
                                    if (i_sts.rc_zero && !i_sts.q_empty) begin
                                        n_state = S_GRANT;
                                    end else begin
                                        o_cmd.emit = 1'b1;
                                        o_cmd.status = frwl_pkg::ST_RELEASED;
                                    end
                                end
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_GRANT: begin
                // wake the head writer, or the next reader of the leading run
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.status = frwl_pkg::ST_WAITER;
                    o_cmd.use_head = 1'b1;
                    o_cmd.pop = 1'b1;
                    if (i_sts.head_wr) begin
                        o_cmd.wr = 1'b1;
                        o_cmd.set_wh = 1'b1;
                        o_cmd.last = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.inc_rc = 1'b1;
                        o_cmd.last = !i_sts.grant_more;
                        n_state = i_sts.grant_more ? S_GWAIT : S_IDLE;
                    end
                end
            end
            S_GWAIT: begin
                // queue read data catches up with the new head
                n_state = S_GRANT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/fair_reader_writer_lock_unit.sv @@
// top level of the fifo-fair reader-writer lock unit
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------------
//  request | in        | i_in_valid / o_in_stall | i_operation, i_requester_id
//  result  | out       | o_out_valid/ i_out_stall | o_status, o_grant_id, o_grant_is_writer, o_last
//
// an item is accepted, then decided and its result written to the result register once
// that register is free; a release that wakes waiters passes S_GRANT for the first woken
// waiter and S_GWAIT then S_GRANT for each further reader of the run, set by the
// registered read of the wait queue. reset is synchronous and clears the counters,
// pointers, flags and state only; queue entries stay undefined until written, so
// there is no clearing pass. a result waits in the output register while i_out_stall
// is high; the next item is taken while the final result of the previous one still waits.
`timescale 1ns / 1ps

module fair_reader_writer_lock_unit #(
    parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [frwl_pkg::OP_W-1:0]   i_operation,
    input  logic [frwl_pkg::ID_W-1:0]   i_requester_id,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [frwl_pkg::ST_W-1:0]   o_status,
    output logic [frwl_pkg::ID_W-1:0]   o_grant_id,
    output logic                        o_grant_is_writer,
    output logic                        o_last
);

    frwl_pkg::t_dp_cmd cmd;
    frwl_pkg::t_dp_sts sts;

    // sequencing
    frwl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // lock state and queue
    frwl_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_operation       (i_operation),
        .i_requester_id    (i_requester_id),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_grant_id        (o_grant_id),
        .o_grant_is_writer (o_grant_is_writer),
        .o_last            (o_last)
    );

endmodule

@@ rtl/frwl_checker.sv @@
// port-level checker of the lock unit and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frwl_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [frwl_pkg::ST_W-1:0] o_status,
    input logic [frwl_pkg::ID_W-1:0] o_grant_id,
    input logic                      o_grant_is_writer,
    input logic                      o_last
);

    // no result survives a reset
    `FRWL_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // a held result keeps its payload
    `FRWL_ASSERT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable({o_status, o_grant_id, o_grant_is_writer, o_last}), "result changed while stalled")

    // only a woken waiter can be followed by more results of the same item
    `FRWL_ASSERT(a_single_last, i_clk, i_rst_n, o_out_valid && (o_status != frwl_pkg::ST_WAITER) |-> o_last, "non-wake result without last")

    // no new item while a drain is still in progress
    `FRWL_ASSERT(a_drain_blocks, i_clk, i_rst_n, o_out_valid && !o_last |-> o_in_stall, "item taken during a drain")

    // status stays within its codes
    `FRWL_ASSERT(a_status_code, i_clk, i_rst_n, o_out_valid |-> (o_status <= frwl_pkg::ST_ERROR), "status code out of range")

endmodule

bind fair_reader_writer_lock_unit frwl_checker u_frwl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_status          (o_status),
    .o_grant_id        (o_grant_id),
    .o_grant_is_writer (o_grant_is_writer),
    .o_last            (o_last)
);
